// ===== hdl/fpa_pkg.sv =====
// Shared constants, types and helpers of the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CMD_W     = 4;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ADD      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MIN      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MAX      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_INC      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DEC      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FROM_INT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_TO_INT   = 4'd9;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic less;
        logic equal;
        logic greater;
        logic div_zero;
    } flags_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  res;
        flags_t                    flags;
        logic signed [DATA_W-1:0]  a;
        logic signed [DATA_W-1:0]  b;
        logic                      neg;
        logic [NUM_W-1:0]          num;
        logic [DATA_W-1:0]         den;
    } op_t;

    // Drop the fraction bits, rounding toward zero, keep the low word.
    function automatic logic [DATA_W-1:0] trunc_frac(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] sum;
        bias = p[PROD_W-1] ? {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}} : '0;
        sum  = p + bias;
        return sum[FRAC_BITS +: DATA_W];
    endfunction

endpackage

// ===== hdl/fpa_in_if.sv =====
// Input channel: opcode and two raw operands.
interface fpa_in_if
    import fpa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

// ===== hdl/fpa_out_if.sv =====
// Output channel: result word and flags.
interface fpa_out_if
    import fpa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic                     a_less;
    logic                     a_equal;
    logic                     a_greater;
    logic                     divide_by_zero;

    modport source (output valid, result, a_less, a_equal, a_greater, divide_by_zero,
                    input ready);
    modport sink   (input valid, result, a_less, a_equal, a_greater, divide_by_zero,
                    output ready);
endinterface

// ===== hdl/fixed_point_alu_q24_8_top.sv =====
// Q24.8 fixed-point ALU, top level.
//
// Channels: "in" carries cmd, operand_a, operand_b; "out" carries result,
// a_less, a_equal, a_greater, divide_by_zero. An item moves on valid && ready.
// Every input item gives exactly one result item, in order.
//
// Throughput: one item per cycle while the receiver keeps ready high. Every
// opcode takes the same path: front register, queue, the divider (one quotient
// bit per stage over the 40-bit scaled dividend) and the output register.
// Multiply takes a 32x32 product, then a rounding stage.
//
// Reset clears all valid bits; no item is in flight afterwards.
// When the receiver holds ready low with a result waiting, the whole back
// pipeline freezes, the two-entry queue fills, then the front stops taking items.
module fixed_point_alu_q24_8_top
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fpa_in_if.sink    in,
    fpa_out_if.source out
);

    logic fq_valid;
    logic fq_ready;
    op_t  fq_data;
    logic qb_valid;
    logic qb_ready;
    op_t  qb_data;

    fpa_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in      (in),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    fpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .out     (out)
    );

endmodule

// ===== hdl/fpa_front.sv =====
// Front end: accepts items, compares operands, resolves simple ops, preps mul/div.
module fpa_front
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fpa_in_if.sink    in,
    output logic      q_valid,
    input  logic      q_ready,
    output op_t       q_data
);

    logic valid_reg;
    op_t  op_reg;
    op_t  op_next;

    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W-1:0]        abs_a;
    logic [DATA_W-1:0]        abs_b;

    assign in.ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = op_reg;

    always_comb
    begin
        a     = in.operand_a;
        b     = in.operand_b;
        abs_a = a[DATA_W-1] ? -a : a;
        abs_b = b[DATA_W-1] ? -b : b;

        op_next                = '0;
        op_next.kind           = KIND_SIMPLE;
        op_next.flags.less     = (a < b);
        op_next.flags.equal    = (a == b);
        op_next.flags.greater  = (a > b);
        op_next.a              = a;
        op_next.b              = b;
        op_next.neg            = a[DATA_W-1] ^ b[DATA_W-1];
        op_next.num            = {abs_a, {FRAC_BITS{1'b0}}};
        op_next.den            = abs_b;

        unique case (in.cmd)
            CMD_ADD:      op_next.res = a + b;
            CMD_SUB:      op_next.res = a - b;
            CMD_MUL:      op_next.kind = KIND_MUL;
            CMD_DIV:
            begin
                if (b == '0)
                    op_next.flags.div_zero = 1'b1;
                else
                    op_next.kind = KIND_DIV;
            end
            CMD_MIN:      op_next.res = (a > b) ? b : a;
            CMD_MAX:      op_next.res = (a < b) ? b : a;
            CMD_INC:      op_next.res = a + DATA_W'(1);
            CMD_DEC:      op_next.res = a - DATA_W'(1);
            CMD_FROM_INT: op_next.res = a <<< FRAC_BITS;
            CMD_TO_INT:   op_next.res = trunc_frac({{DATA_W{a[DATA_W-1]}}, a});
            default:      op_next.res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in.ready)
            valid_reg <= in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
            op_reg <= op_next;
    end

endmodule

// ===== hdl/fpa_queue.sv =====
// Short queue between front and back end.
module fpa_queue
    import fpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_data
);

    op_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign pop_valid  = (count_reg != '0);
    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH)) || pop_ready;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count missed a pop");

endmodule

// ===== hdl/fpa_back.sv =====
// Back end: multiplier and radix-2 pipelined divider, output register.
module fpa_back
    import fpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  op_t       q_data,
    fpa_out_if.source out
);

    typedef struct packed {
        kind_t                    kind;
        logic signed [DATA_W-1:0] res;
        flags_t                   flags;
        logic                     neg;
        logic [DATA_W-1:0]        rem;
        logic [NUM_W-1:0]         num;
        logic [DATA_W-1:0]        quo;
        logic [DATA_W-1:0]        den;
    } stage_t;

    logic                     vld_reg [0:NUM_W];
    stage_t                   st_reg  [0:NUM_W];
    stage_t                   st_next [0:NUM_W];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_res_reg;
    logic signed [DATA_W-1:0] out_res_next;
    flags_t                   out_flags_reg;
    logic                     advance;

    function automatic stage_t div_step(input stage_t s);
        stage_t          r;
        logic [DATA_W:0] partial;
        logic [DATA_W:0] diff;
        logic            ge;
        r       = s;
        partial = {s.rem, s.num[NUM_W-1]};
        diff    = partial - {1'b0, s.den};
        ge      = (partial >= {1'b0, s.den});
        r.rem   = ge ? diff[DATA_W-1:0] : partial[DATA_W-1:0];
        r.num   = {s.num[NUM_W-2:0], 1'b0};
        r.quo   = {s.quo[DATA_W-2:0], ge};
        return r;
    endfunction

    // whole pipeline moves together; stalls only when the output is held
    assign advance = !out_valid_reg || out.ready;
    assign q_ready = advance;

    always_comb
    begin
        st_next[0].kind  = q_data.kind;
        st_next[0].res   = q_data.res;
        st_next[0].flags = q_data.flags;
        st_next[0].neg   = q_data.neg;
        st_next[0].rem   = '0;
        st_next[0].num   = q_data.num;
        st_next[0].quo   = '0;
        st_next[0].den   = q_data.den;
        prod_next        = q_data.a * q_data.b;

        for (int i = 0; i < NUM_W; i++)
        begin
            st_next[i+1] = div_step(st_reg[i]);
        end
        if (st_reg[0].kind == KIND_MUL)
            st_next[1].res = trunc_frac(prod_reg);

        if (st_reg[NUM_W].kind == KIND_DIV)
            out_res_next = st_reg[NUM_W].neg ? -st_reg[NUM_W].quo : st_reg[NUM_W].quo;
        else
            out_res_next = st_reg[NUM_W].res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_W; i++)
                vld_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i <= NUM_W; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_valid_reg <= vld_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i <= NUM_W; i++)
                st_reg[i] <= st_next[i];
            prod_reg      <= prod_next;
            out_res_reg   <= out_res_next;
            out_flags_reg <= st_reg[NUM_W].flags;
        end
    end

    assign out.valid          = out_valid_reg;
    assign out.result         = out_res_reg;
    assign out.a_less         = out_flags_reg.less;
    assign out.a_equal        = out_flags_reg.equal;
    assign out.a_greater      = out_flags_reg.greater;
    assign out.divide_by_zero = out_flags_reg.div_zero;

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> $onehot({out.a_less, out.a_equal, out.a_greater}))
        else $error("compare flags not one-hot");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.divide_by_zero) |-> (out.result == '0))
        else $error("zero divisor gave nonzero result");

    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && st_reg[0].kind == KIND_DIV) |-> (st_reg[0].den != '0))
        else $error("divide entered with zero divisor");

endmodule

// ===== sim/tb_fixed_point_alu_q24_8_top.sv =====
// Testbench for the Q24.8 fixed-point ALU: directed table, random items, scoreboard.
`timescale 1ns / 100ps

module tb_fixed_point_alu_q24_8_top;
    import fpa_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] result;
        logic              less;
        logic              equal;
        logic              greater;
        logic              div_zero;
    } alu_res_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        bit                typed;
        logic [DATA_W-1:0] result;
        logic              div_zero;
    } dir_row_t;

    localparam longint ONE_RAW = longint'(1) << FRAC_BITS;

    logic clk;
    logic rst_n;

    fpa_in_if  in_ch();
    fpa_out_if out_ch();

    fixed_point_alu_q24_8_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    alu_res_t pending_q[$];
    int       errors;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("fixed_point_alu_q24_8_top: mismatch");
        $finish;
    end

    function automatic alu_res_t alu_predict(logic [CMD_W-1:0] cmd,
                                             logic [DATA_W-1:0] ra,
                                             logic [DATA_W-1:0] rb);
        alu_res_t r;
        longint a;
        longint b;
        longint v;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        v = 0;
        r.div_zero = 1'b0;
        case (cmd)
            CMD_ADD:      v = a + b;
            CMD_SUB:      v = a - b;
            CMD_MUL:      v = (a * b) / ONE_RAW;
            CMD_DIV:
            begin
                if (b == 0)
                    r.div_zero = 1'b1;
                else
                    v = (a * ONE_RAW) / b;
            end
            CMD_MIN:      v = (a > b) ? b : a;
            CMD_MAX:      v = (a < b) ? b : a;
            CMD_INC:      v = a + 1;
            CMD_DEC:      v = a - 1;
            CMD_FROM_INT: v = a * ONE_RAW;
            CMD_TO_INT:   v = a / ONE_RAW;
            default:      v = 0;
        endcase
        r.result  = v[DATA_W-1:0];
        r.less    = a < b;
        r.equal   = a == b;
        r.greater = a > b;
        return r;
    endfunction

    // Typed rows check the predictor against the table; the DUT is scored against the predictor.
    dir_row_t dir_tbl[] = '{
        '{CMD_ADD,      32'h7fffffff, 32'h00000001, 1, 32'h80000000, 1'b0},
        '{CMD_SUB,      32'h80000000, 32'h00000001, 1, 32'h7fffffff, 1'b0},
        '{CMD_MUL,      32'h00000100, 32'h00000100, 1, 32'h00000100, 1'b0},
        '{CMD_MUL,      32'hffffffff, 32'h00000001, 1, 32'h00000000, 1'b0},
        '{CMD_MUL,      32'h80000000, 32'h80000000, 0, 32'h0, 1'b0},
        '{CMD_MUL,      32'h7fffffff, 32'h80000000, 0, 32'h0, 1'b0},
        '{CMD_DIV,      32'h00001234, 32'h00000000, 1, 32'h00000000, 1'b1},
        '{CMD_DIV,      32'h80000000, 32'h00000000, 1, 32'h00000000, 1'b1},
        '{CMD_DIV,      32'h80000000, 32'hffffffff, 0, 32'h0, 1'b0},
        '{CMD_DIV,      32'h80000000, 32'hffffff00, 0, 32'h0, 1'b0},
        '{CMD_DIV,      32'h7fffffff, 32'h00000001, 0, 32'h0, 1'b0},
        '{CMD_DIV,      32'hfffffd00, 32'h00000200, 0, 32'h0, 1'b0},
        '{CMD_MIN,      32'h80000000, 32'h7fffffff, 1, 32'h80000000, 1'b0},
        '{CMD_MAX,      32'h80000000, 32'h7fffffff, 1, 32'h7fffffff, 1'b0},
        '{CMD_MIN,      32'h00000005, 32'h00000005, 1, 32'h00000005, 1'b0},
        '{CMD_INC,      32'h7fffffff, 32'h00000000, 1, 32'h80000000, 1'b0},
        '{CMD_DEC,      32'h80000000, 32'h00000000, 1, 32'h7fffffff, 1'b0},
        '{CMD_FROM_INT, 32'h00800000, 32'h00000000, 1, 32'h80000000, 1'b0},
        '{CMD_FROM_INT, 32'hffffffff, 32'h00000000, 1, 32'hffffff00, 1'b0},
        '{CMD_TO_INT,   32'hffffff01, 32'h00000000, 1, 32'h00000000, 1'b0},
        '{CMD_TO_INT,   32'h80000000, 32'h00000000, 1, 32'hff800000, 1'b0},
        '{4'd10,        32'h12345678, 32'h12345678, 1, 32'h00000000, 1'b0},
        '{4'd15,        32'hffffffff, 32'h00000000, 1, 32'h00000000, 1'b0}
    };

    // Valid stays high between back-to-back items; it drops only while idling.
    task automatic send_op(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] a,
                           logic [DATA_W-1:0] b);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_q.push_back(alu_predict(cmd, a, b));
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(7))
            0: return 32'h80000000 + $urandom_range(3);
            1: return 32'h7fffffff - $urandom_range(3);
            2: return $urandom_range(1023) - 512;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
    endtask

    // Receiver side: random stalls plus an optional long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        alu_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %h", $time, out_ch.result);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (out_ch.result !== e.result || out_ch.a_less !== e.less
                    || out_ch.a_equal !== e.equal || out_ch.a_greater !== e.greater
                    || out_ch.divide_by_zero !== e.div_zero)
                begin
                    $display("%0t: expected res=%h l/e/g/dz=%b%b%b%b, got res=%h %b%b%b%b",
                             $time, e.result, e.less, e.equal, e.greater, e.div_zero,
                             out_ch.result, out_ch.a_less, out_ch.a_equal,
                             out_ch.a_greater, out_ch.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        alu_res_t p;
        int n;
        errors          = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = '0;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].typed)
            begin
                p = alu_predict(dir_tbl[i].cmd, dir_tbl[i].a, dir_tbl[i].b);
                if (p.result !== dir_tbl[i].result || p.div_zero !== dir_tbl[i].div_zero)
                begin
                    $display("%0t: table row %0d expected %h, predictor %h",
                             $time, i, dir_tbl[i].result, p.result);
                    errors++;
                end
            end
            send_op(dir_tbl[i].cmd, dir_tbl[i].a, dir_tbl[i].b);
        end
        drain();

        // Long receiver hold-off while items keep coming: fills the pipe.
        hold_cycles = 150;
        for (n = 0; n < 60; n++)
            send_op(CMD_W'($urandom_range(15)), rand_operand(), rand_operand());
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (n = 0; n < 135; n++)
                send_op(CMD_W'($urandom_range(15)), rand_operand(), rand_operand());
            // sender pauses until everything is back
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (60) @(negedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("fixed_point_alu_q24_8_top: match");
        else
            $display("fixed_point_alu_q24_8_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fpa_pkg.sv
hdl/fpa_in_if.sv
hdl/fpa_out_if.sv
hdl/fpa_front.sv
hdl/fpa_queue.sv
hdl/fpa_back.sv
hdl/fixed_point_alu_q24_8_top.sv
sim/tb_fixed_point_alu_q24_8_top.sv
